/* src/iopt_pkg.sv */
// ----------------------------------------------------------------------------
// iopt_pkg
// Shared types and constants of the I/O page translation table: the request
// and response words, operation and status codes, and queue sizes.
// ----------------------------------------------------------------------------
package iopt_pkg;

  localparam int unsigned ADDR_W      = 48;
  localparam int unsigned CNT_W       = 13;
  localparam int unsigned BYTE_W      = 25;
  localparam logic [BYTE_W-1:0] BYTES_MAX = 25'h1FF_FFFF;

  localparam int unsigned CMD_DEPTH   = 2;
  localparam int unsigned RSP_DEPTH   = 4;
  localparam int unsigned RSP_CNT_W   = $clog2(RSP_DEPTH + 1);

  typedef enum logic [1:0] {
    MODE_MAP   = 2'd0,
    MODE_UNMAP = 2'd1,
    MODE_XLAT  = 2'd2,
    MODE_NOP   = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_MISALIGN = 2'd1,
    ST_BUSY     = 2'd2,
    ST_RANGE    = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    K_REPLY = 2'd0,
    K_MAP   = 2'd1,
    K_UNMAP = 2'd2,
    K_XLAT  = 2'd3
  } kind_e;

  typedef struct packed {
    logic [1:0]        mode;
    logic [ADDR_W-1:0] io_address;
    logic [ADDR_W-1:0] phys_address;
    logic [CNT_W-1:0]  page_count;
  } req_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [BYTE_W-1:0] byte_count;
    logic [ADDR_W-1:0] translated_address;
  } rsp_t;

endpackage

/* src/iopt_fifo.sv */
// ----------------------------------------------------------------------------
// iopt_fifo
// Small register queue between the front and back parts, and in front of the
// result port.
// ----------------------------------------------------------------------------
module iopt_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2,
  localparam int unsigned CntW = $clog2(DEPTH + 1)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             pop_i,
  output logic [WIDTH-1:0] rdata_o,
  output logic             full_o,
  output logic             empty_o,
  output logic [CntW-1:0]  count_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [WIDTH-1:0] slot_q [DEPTH];
  logic [PtrW-1:0]  wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign count_o = cnt_q;
  assign rdata_o = slot_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == PtrW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
    end
    if (do_pop) begin
      rd_d = (rd_q == PtrW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_q] <= wdata_i;
    end
  end

endmodule

/* src/iopt_front.sv */
// ----------------------------------------------------------------------------
// iopt_front
// Input side: takes request words, checks alignment and table bounds, and
// turns each into a back-part command: table work or a ready-made reply.
// ----------------------------------------------------------------------------
module iopt_front #(
  parameter int unsigned TABLE_ENTRIES = 4096,
  parameter int unsigned PAGE_BITS     = 12,
  parameter int unsigned ADDRESS_BITS  = 48,
  localparam int unsigned IdxW  = $clog2(TABLE_ENTRIES),
  localparam int unsigned EffAw = (ADDRESS_BITS < iopt_pkg::ADDR_W) ?
                                  ADDRESS_BITS : iopt_pkg::ADDR_W,
  localparam int unsigned PpnW  = EffAw - PAGE_BITS,
  localparam int unsigned CmdW  = 4 + IdxW + PpnW + PAGE_BITS + iopt_pkg::CNT_W
) (
  input  logic                 push_i,
  input  iopt_pkg::req_t       word_i,
  input  logic                 cmd_full_i,
  input  logic                 clearing_i,
  output logic                 full_o,
  output logic                 cmd_push_o,
  output logic [CmdW-1:0]      cmd_o
);

  import iopt_pkg::*;

  localparam int unsigned CmpA = (PpnW > IdxW + 1) ? PpnW : IdxW + 1;
  localparam int unsigned CmpW = ((CmpA > CNT_W) ? CmpA : CNT_W) + 1;

  typedef struct packed {
    kind_e                kind;
    status_e              status;
    logic [IdxW-1:0]      page;
    logic [PpnW-1:0]      ppn;
    logic [PAGE_BITS-1:0] offset;
    logic [CNT_W-1:0]     count;
  } cmd_t;

  logic [EffAw-1:0]     ioa, pa;
  logic [PAGE_BITS-1:0] io_off, pa_off;
  logic [CmpW-1:0]      iopn_ext, cnt_ext, ent_c;
  logic                 in_tbl, fits;
  cmd_t                 cmd;

  assign full_o     = cmd_full_i || clearing_i;
  assign cmd_push_o = push_i && !full_o;

  assign ioa      = word_i.io_address[EffAw-1:0];
  assign pa       = word_i.phys_address[EffAw-1:0];
  assign io_off   = ioa[PAGE_BITS-1:0];
  assign pa_off   = pa[PAGE_BITS-1:0];
  assign iopn_ext = CmpW'(ioa[EffAw-1:PAGE_BITS]);
  assign cnt_ext  = CmpW'(word_i.page_count);
  assign ent_c    = CmpW'(TABLE_ENTRIES);
  assign in_tbl   = (iopn_ext < ent_c);
  assign fits     = in_tbl && ((iopn_ext + cnt_ext) <= ent_c);

  always_comb begin
    cmd        = '0;
    cmd.kind   = K_REPLY;
    cmd.status = ST_OK;
    cmd.page   = iopn_ext[IdxW-1:0];
    cmd.ppn    = pa[EffAw-1:PAGE_BITS];
    cmd.offset = io_off;
    cmd.count  = word_i.page_count;
    case (word_i.mode)
      MODE_MAP: begin
        if ((io_off != '0) || (pa_off != '0)) begin
          cmd.status = ST_MISALIGN;
        end else if (!fits) begin
          cmd.status = ST_RANGE;
        end else if (word_i.page_count != '0) begin
          cmd.kind = K_MAP;
        end
      end
      MODE_UNMAP: begin
        if (io_off != '0) begin
          cmd.status = ST_MISALIGN;
        end else if (!fits) begin
          cmd.status = ST_RANGE;
        end else if (word_i.page_count != '0) begin
          cmd.kind = K_UNMAP;
        end
      end
      MODE_XLAT: begin
        if (!in_tbl) begin
          cmd.status = ST_RANGE;
        end else begin
          cmd.kind = K_XLAT;
        end
      end
      default: begin
        cmd.kind = K_REPLY;
      end
    endcase
  end

  assign cmd_o = cmd;

endmodule

/* src/iopt_back.sv */
// ----------------------------------------------------------------------------
// iopt_back
// Table side: owns the page table memory, clears it after reset, and runs
// translate lookups, map scans and fills, and unmap walks.
// ----------------------------------------------------------------------------
module iopt_back #(
  parameter int unsigned TABLE_ENTRIES = 4096,
  parameter int unsigned PAGE_BITS     = 12,
  parameter int unsigned ADDRESS_BITS  = 48,
  localparam int unsigned IdxW  = $clog2(TABLE_ENTRIES),
  localparam int unsigned EffAw = (ADDRESS_BITS < iopt_pkg::ADDR_W) ?
                                  ADDRESS_BITS : iopt_pkg::ADDR_W,
  localparam int unsigned PpnW  = EffAw - PAGE_BITS,
  localparam int unsigned CmdW  = 4 + IdxW + PpnW + PAGE_BITS + iopt_pkg::CNT_W
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cmd_valid_i,
  input  logic [CmdW-1:0]                cmd_i,
  output logic                           cmd_pop_o,
  input  logic [iopt_pkg::RSP_CNT_W-1:0] rsp_count_i,
  input  logic                           rsp_full_i,
  output logic                           rsp_push_o,
  output iopt_pkg::rsp_t                 rsp_o,
  output logic                           clearing_o
);

  import iopt_pkg::*;

  localparam int unsigned SumW  = ((IdxW > CNT_W) ? IdxW : CNT_W) + 1;
  localparam int unsigned ShW   = (CNT_W + PAGE_BITS > BYTE_W) ?
                                  CNT_W + PAGE_BITS : BYTE_W + 1;
  localparam int unsigned RoomW = RSP_CNT_W + 1;

  typedef struct packed {
    kind_e                kind;
    status_e              status;
    logic [IdxW-1:0]      page;
    logic [PpnW-1:0]      ppn;
    logic [PAGE_BITS-1:0] offset;
    logic [CNT_W-1:0]     count;
  } cmd_t;

  typedef struct packed {
    logic            valid;
    logic [PpnW-1:0] ppn;
  } ent_t;

  typedef enum logic [5:0] {
    S_CLEAR = 6'b000001,
    S_IDLE  = 6'b000010,
    S_SCAN  = 6'b000100,
    S_FILL  = 6'b001000,
    S_UNMAP = 6'b010000,
    S_REPLY = 6'b100000
  } state_e;

  function automatic logic [BYTE_W-1:0] bytes_of(input logic [CNT_W-1:0] n);
    logic [ShW-1:0] sh;
    sh = ShW'(n) << PAGE_BITS;
    if (sh > ShW'(BYTES_MAX)) begin
      bytes_of = BYTES_MAX;
    end else begin
      bytes_of = sh[BYTE_W-1:0];
    end
  endfunction

  ent_t table_mem [TABLE_ENTRIES];
  ent_t rd_q;

  state_e               state_q, state_d;
  logic [IdxW-1:0]      clr_q, clr_d;
  logic [CNT_W-1:0]     idx_q, idx_d;
  logic                 phase_q, phase_d;
  logic                 xp_q, xp_d;
  logic [IdxW-1:0]      base_q, base_d;
  logic [PpnW-1:0]      ppn_q, ppn_d;
  logic [CNT_W-1:0]     cnt_q, cnt_d;
  logic [PAGE_BITS-1:0] xoff_q, xoff_d;
  status_e              st_q, st_d;
  logic [BYTE_W-1:0]    bytes_q, bytes_d;

  cmd_t             cmd;
  logic [SumW-1:0]  run_sum;
  logic [IdxW-1:0]  run_addr;
  logic [CNT_W-1:0] idx_inc;
  logic             room;
  logic             re, we;
  logic [IdxW-1:0]  raddr, waddr;
  ent_t             wdata;
  logic [EffAw-1:0] xa;

  assign cmd        = cmd_i;
  assign run_sum    = SumW'(base_q) + SumW'(idx_q);
  assign run_addr   = run_sum[IdxW-1:0];
  assign idx_inc    = idx_q + 1'b1;
  assign room       = (RoomW'(rsp_count_i) + RoomW'(xp_q)) < RoomW'(RSP_DEPTH);
  assign clearing_o = (state_q == S_CLEAR);
  assign xa         = {rd_q.ppn, xoff_q};

  always_comb begin
    state_d   = state_q;
    clr_d     = clr_q;
    idx_d     = idx_q;
    phase_d   = phase_q;
    xp_d      = 1'b0;
    base_d    = base_q;
    ppn_d     = ppn_q;
    cnt_d     = cnt_q;
    xoff_d    = xoff_q;
    st_d      = st_q;
    bytes_d   = bytes_q;
    cmd_pop_o = 1'b0;
    re        = 1'b0;
    we        = 1'b0;
    raddr     = run_addr;
    waddr     = run_addr;
    wdata     = '0;
    case (state_q)
      S_CLEAR: begin
        we    = 1'b1;
        waddr = clr_q;
        clr_d = clr_q + 1'b1;
        if (clr_q == IdxW'(TABLE_ENTRIES - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (cmd_valid_i) begin
          base_d  = cmd.page;
          ppn_d   = cmd.ppn;
          cnt_d   = cmd.count;
          idx_d   = '0;
          phase_d = 1'b0;
          case (cmd.kind)
            K_XLAT: begin
              if (room) begin
                re        = 1'b1;
                raddr     = cmd.page;
                xp_d      = 1'b1;
                xoff_d    = cmd.offset;
                cmd_pop_o = 1'b1;
              end
            end
            K_MAP: begin
              cmd_pop_o = 1'b1;
              state_d   = S_SCAN;
            end
            K_UNMAP: begin
              cmd_pop_o = 1'b1;
              state_d   = S_UNMAP;
            end
            default: begin
              cmd_pop_o = 1'b1;
              st_d      = cmd.status;
              bytes_d   = '0;
              state_d   = S_REPLY;
            end
          endcase
        end
      end
      S_SCAN: begin
        if (!phase_q) begin
          re      = 1'b1;
          phase_d = 1'b1;
        end else begin
          phase_d = 1'b0;
          if (rd_q.valid) begin
            st_d    = ST_BUSY;
            bytes_d = '0;
            state_d = S_REPLY;
          end else if (idx_inc == cnt_q) begin
            idx_d   = '0;
            state_d = S_FILL;
          end else begin
            idx_d = idx_inc;
          end
        end
      end
      S_FILL: begin
        we        = 1'b1;
        wdata.valid = 1'b1;
        wdata.ppn = ppn_q + PpnW'(idx_q);
        idx_d     = idx_inc;
        if (idx_inc == cnt_q) begin
          st_d    = ST_OK;
          bytes_d = bytes_of(cnt_q);
          state_d = S_REPLY;
        end
      end
      S_UNMAP: begin
        if (!phase_q) begin
          if (idx_q == cnt_q) begin
            st_d    = ST_OK;
            bytes_d = bytes_of(idx_q);
            state_d = S_REPLY;
          end else begin
            re      = 1'b1;
            phase_d = 1'b1;
          end
        end else begin
          phase_d = 1'b0;
          if (rd_q.valid) begin
            we    = 1'b1;
            idx_d = idx_inc;
          end else begin
            st_d    = ST_OK;
            bytes_d = bytes_of(idx_q);
            state_d = S_REPLY;
          end
        end
      end
      S_REPLY: begin
        if (!rsp_full_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    rsp_o      = '0;
    rsp_push_o = 1'b0;
    if (xp_q) begin
      rsp_push_o = 1'b1;
      rsp_o.status = ST_OK;
      if (rd_q.valid) begin
        rsp_o.translated_address = ADDR_W'(xa);
      end
    end else if ((state_q == S_REPLY) && !rsp_full_i) begin
      rsp_push_o       = 1'b1;
      rsp_o.status     = st_q;
      rsp_o.byte_count = bytes_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      clr_q   <= '0;
      idx_q   <= '0;
      phase_q <= 1'b0;
      xp_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      idx_q   <= idx_d;
      phase_q <= phase_d;
      xp_q    <= xp_d;
    end
  end

  always_ff @(posedge clk_i) begin
    base_q  <= base_d;
    ppn_q   <= ppn_d;
    cnt_q   <= cnt_d;
    xoff_q  <= xoff_d;
    st_q    <= st_d;
    bytes_q <= bytes_d;
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      table_mem[waddr] <= wdata;
    end
    if (re) begin
      rd_q <= table_mem[raddr];
    end
  end

endmodule

/* src/io_page_translation_table_core.sv */
// ----------------------------------------------------------------------------
// io_page_translation_table_core
// Single-level I/O page translation table with map, unmap and translate.
// ----------------------------------------------------------------------------
// After reset the table is swept clear, one entry per cycle; full stays high
// during the sweep. Translates issue back to back, one per cycle while the
// result queue has room, and each result comes from the registered table
// read into the result queue. A map first reads and checks each entry of the
// run, then, if none is in use, writes every entry in a second pass; an
// unmap reads each entry and clears it if valid, stopping at the end of the
// run or at the first hole. Each map and unmap starts from the idle state and
// ends in the reply state. The table memory serves one access at a time and
// its read is registered. Requests queue ahead of the table and results queue behind it.
module io_page_translation_table_core #(
  parameter int unsigned TABLE_ENTRIES = 4096,
  parameter int unsigned PAGE_BITS     = 12,
  parameter int unsigned ADDRESS_BITS  = 48
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push,
  output logic           full,
  input  iopt_pkg::req_t in_word_i,
  output logic           empty,
  input  logic           pop,
  output iopt_pkg::rsp_t out_word_o
);

  import iopt_pkg::*;

  localparam int unsigned IdxW  = $clog2(TABLE_ENTRIES);
  localparam int unsigned EffAw = (ADDRESS_BITS < ADDR_W) ? ADDRESS_BITS : ADDR_W;
  localparam int unsigned PpnW  = EffAw - PAGE_BITS;
  localparam int unsigned CmdW  = 4 + IdxW + PpnW + PAGE_BITS + CNT_W;
  localparam int unsigned RspW  = $bits(rsp_t);

  logic                 cmd_push, cmd_full, cmd_empty, cmd_pop, clearing;
  logic [CmdW-1:0]      cmd_in, cmd_out;
  logic [$clog2(CMD_DEPTH + 1)-1:0] cmd_count;
  logic                 rsp_push, rsp_full;
  logic [RSP_CNT_W-1:0] rsp_count;
  rsp_t                 rsp_in;
  logic [RspW-1:0]      rsp_out;

  iopt_front #(
    .TABLE_ENTRIES(TABLE_ENTRIES),
    .PAGE_BITS    (PAGE_BITS),
    .ADDRESS_BITS (ADDRESS_BITS)
  ) u_front (
    .push_i    (push),
    .word_i    (in_word_i),
    .cmd_full_i(cmd_full),
    .clearing_i(clearing),
    .full_o    (full),
    .cmd_push_o(cmd_push),
    .cmd_o     (cmd_in)
  );

  iopt_fifo #(
    .WIDTH(CmdW),
    .DEPTH(CMD_DEPTH)
  ) u_cmd_q (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (cmd_push),
    .wdata_i(cmd_in),
    .pop_i  (cmd_pop),
    .rdata_o(cmd_out),
    .full_o (cmd_full),
    .empty_o(cmd_empty),
    .count_o(cmd_count)
  );

  iopt_back #(
    .TABLE_ENTRIES(TABLE_ENTRIES),
    .PAGE_BITS    (PAGE_BITS),
    .ADDRESS_BITS (ADDRESS_BITS)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_valid_i(!cmd_empty),
    .cmd_i      (cmd_out),
    .cmd_pop_o  (cmd_pop),
    .rsp_count_i(rsp_count),
    .rsp_full_i (rsp_full),
    .rsp_push_o (rsp_push),
    .rsp_o      (rsp_in),
    .clearing_o (clearing)
  );

  iopt_fifo #(
    .WIDTH(RspW),
    .DEPTH(RSP_DEPTH)
  ) u_rsp_q (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (rsp_push),
    .wdata_i(rsp_in),
    .pop_i  (pop),
    .rdata_o(rsp_out),
    .full_o (rsp_full),
    .empty_o(empty),
    .count_o(rsp_count)
  );

  assign out_word_o = rsp_out;

  a_rsp_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_push |-> !rsp_full) else $error("result pushed into full queue");

  a_cmd_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_push |-> (!cmd_full && (cmd_count < ($clog2(CMD_DEPTH + 1))'(CMD_DEPTH))))
    else $error("command pushed into full queue");

  a_no_work_while_clearing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clearing |-> (!cmd_push && !cmd_pop && !rsp_push))
    else $error("table used during clearing pass");

  a_no_result_while_clearing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clearing |-> empty) else $error("result present during clearing pass");

endmodule

/* bench/io_page_translation_table_core_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// io_page_translation_table_core_tb
// Self-checking bench for the I/O page translation table. A directed pass
// covers alignment errors, runs past the end of the table, busy maps, empty
// runs, physical page wrap, unmap stopping at a hole, full-table map and
// unmap, and no-op words. Random passes follow: mostly well-formed map, unmap and
// translate streams, raw noise words, and back-to-back translates. A shadow
// table predicts every response, and each popped word is compared field by
// field in order. Both queue sides idle at random.
// ----------------------------------------------------------------------------
module io_page_translation_table_core_tb;
  import iopt_pkg::*;

  localparam int unsigned TABLE_ENTRIES = 4096;
  localparam int unsigned PAGE_BITS     = 12;
  localparam int unsigned PPN_W         = ADDR_W - PAGE_BITS;
  localparam int unsigned IDLE_LIMIT    = 60000;

  logic clk_i;
  logic rst_ni;
  logic push;
  logic full;
  req_t in_word_i;
  logic empty;
  logic pop;
  rsp_t out_word_o;

  bit             pte_valid [TABLE_ENTRIES];
  logic [PPN_W-1:0] pte_ppn [TABLE_ENTRIES];
  rsp_t           expected_rsp_q [$];
  int unsigned    map_starts [$];
  int unsigned    err_count;
  int unsigned    idle_cycles;
  int unsigned    rx_stall;
  bit             tx_steady;
  bit             rx_steady;

  io_page_translation_table_core #(
    .TABLE_ENTRIES(TABLE_ENTRIES),
    .PAGE_BITS    (PAGE_BITS),
    .ADDRESS_BITS (ADDR_W)
  ) DUT (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push      (push),
    .full      (full),
    .in_word_i (in_word_i),
    .empty     (empty),
    .pop       (pop),
    .out_word_o(out_word_o)
  );

  always begin
    clk_i = 1'b1;
    #4;
    clk_i = 1'b0;
    #4;
  end

  function automatic int unsigned pick_gap();
    if ($urandom_range(0, 9) == 0) return $urandom_range(10, 40);
    return $urandom_range(1, 3);
  endfunction

  function automatic logic [BYTE_W-1:0] bytes_of(longint unsigned pages);
    longint unsigned b;
    b = pages << PAGE_BITS;
    return (b > BYTES_MAX) ? BYTES_MAX : b[BYTE_W-1:0];
  endfunction

  function automatic bit run_fits(longint unsigned start, longint unsigned cnt);
    if (start >= TABLE_ENTRIES) return 1'b0;
    return cnt <= TABLE_ENTRIES - start;
  endfunction

  function automatic rsp_t predict_table_op(req_t w);
    rsp_t                  r;
    logic [PPN_W-1:0]      io_pg;
    logic [PPN_W-1:0]      ph_pg;
    logic [PAGE_BITS-1:0]  io_off;
    logic [PAGE_BITS-1:0]  ph_off;
    longint unsigned       cnt;
    longint unsigned       done;
    bit                    clash;
    r      = '0;
    io_pg  = w.io_address[ADDR_W-1:PAGE_BITS];
    ph_pg  = w.phys_address[ADDR_W-1:PAGE_BITS];
    io_off = w.io_address[PAGE_BITS-1:0];
    ph_off = w.phys_address[PAGE_BITS-1:0];
    cnt    = w.page_count;
    case (mode_e'(w.mode))
      MODE_MAP: begin
        if (io_off != 0 || ph_off != 0) begin
          r.status = ST_MISALIGN;
        end else if (!run_fits(io_pg, cnt)) begin
          r.status = ST_RANGE;
        end else begin
          clash = 1'b0;
          for (longint unsigned i = 0; i < cnt; i++)
            if (pte_valid[io_pg + i]) clash = 1'b1;
          if (clash) begin
            r.status = ST_BUSY;
          end else begin
            for (longint unsigned i = 0; i < cnt; i++) begin
              pte_valid[io_pg + i] = 1'b1;
              pte_ppn[io_pg + i]   = ph_pg + i[PPN_W-1:0];
            end
            r.byte_count = bytes_of(cnt);
          end
        end
      end
      MODE_UNMAP: begin
        if (io_off != 0) begin
          r.status = ST_MISALIGN;
        end else if (!run_fits(io_pg, cnt)) begin
          r.status = ST_RANGE;
        end else begin
          done = 0;
          while (done < cnt && pte_valid[io_pg + done]) begin
            pte_valid[io_pg + done] = 1'b0;
            pte_ppn[io_pg + done]   = '0;
            done++;
          end
          r.byte_count = bytes_of(done);
        end
      end
      MODE_XLAT: begin
        if (io_pg >= TABLE_ENTRIES) r.status = ST_RANGE;
        else if (pte_valid[io_pg]) r.translated_address = {pte_ppn[io_pg], io_off};
      end
      default: r = '0;
    endcase
    return r;
  endfunction

  function automatic req_t make_word(mode_e m, logic [ADDR_W-1:0] ioa,
                                     logic [ADDR_W-1:0] pa, logic [CNT_W-1:0] cnt);
    req_t w;
    w.mode         = m;
    w.io_address   = ioa;
    w.phys_address = pa;
    w.page_count   = cnt;
    return w;
  endfunction

  task automatic send_word(req_t w);
    int unsigned gap;
    gap = (!tx_steady && $urandom_range(0, 3) == 0) ? pick_gap() : 0;
    if (gap != 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    push      <= 1'b1;
    in_word_i <= w;
    do @(posedge clk_i); while (full);
    expected_rsp_q.push_back(predict_table_op(w));
  endtask

  task automatic drain_responses();
    if (push) push <= 1'b0;
    while (expected_rsp_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic flag_mismatch(string field, logic [79:0] got, logic [79:0] want);
    $display("[%0t] mismatch %s: got 0x%0h want 0x%0h", $realtime, field, got, want);
    err_count++;
  endtask

  // hold pop low for random stalls
  always @(posedge clk_i) begin
    if (rx_stall != 0) begin
      rx_stall <= rx_stall - 1;
      pop      <= 1'b0;
    end else if (!rx_steady && $urandom_range(0, 3) == 0) begin
      rx_stall <= pick_gap();
      pop      <= 1'b0;
    end else begin
      pop <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    rsp_t want;
    if (rst_ni && pop && !empty) begin
      if (expected_rsp_q.size() == 0) begin
        flag_mismatch("unexpected word", out_word_o, '0);
      end else begin
        want = expected_rsp_q.pop_front();
        if (out_word_o.status !== want.status)
          flag_mismatch("status", out_word_o.status, want.status);
        if (out_word_o.byte_count !== want.byte_count)
          flag_mismatch("byte_count", out_word_o.byte_count, want.byte_count);
        if (out_word_o.translated_address !== want.translated_address)
          flag_mismatch("translated_address", out_word_o.translated_address,
                        want.translated_address);
      end
    end
  end

  always @(posedge clk_i) begin
    if ((push && !full) || (pop && !empty)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  function automatic logic [CNT_W-1:0] pick_count();
    int unsigned roll;
    roll = $urandom_range(0, 199);
    if (roll < 2) return CNT_W'($urandom_range(256, TABLE_ENTRIES));
    if (roll < 12) return CNT_W'($urandom_range(0, 64));
    return CNT_W'($urandom_range(1, 8));
  endfunction

  function automatic logic [ADDR_W-1:0] page_addr(int unsigned pg);
    logic [ADDR_W-1:0] a;
    a = pg;
    return a << PAGE_BITS;
  endfunction

  function automatic logic [ADDR_W-1:0] rand48();
    return ADDR_W'({$urandom(), $urandom()});
  endfunction

  task automatic test_directed();
    logic [ADDR_W-1:0] top_pa;
    top_pa = {{PPN_W{1'b1}}, {PAGE_BITS{1'b0}}};
    send_word(make_word(MODE_XLAT, '0, '0, '0));
    send_word(make_word(MODE_NOP, '1, '1, '1));
    send_word(make_word(MODE_MAP, 48'h1, '0, 13'd1));
    send_word(make_word(MODE_MAP, '0, 48'h800, 13'd1));
    send_word(make_word(MODE_UNMAP, 48'hFFF, '0, 13'd1));
    send_word(make_word(MODE_MAP, page_addr(TABLE_ENTRIES), '0, 13'd1));
    send_word(make_word(MODE_MAP, page_addr(TABLE_ENTRIES - 1), '0, 13'd2));
    send_word(make_word(MODE_MAP, '0, '0, '1));
    send_word(make_word(MODE_MAP, page_addr(7), '0, 13'd0));
    send_word(make_word(MODE_MAP, '0, top_pa, 13'd4));
    send_word(make_word(MODE_XLAT, page_addr(0) | 48'h5A5, '0, '0));
    send_word(make_word(MODE_XLAT, page_addr(3) | 48'hFFF, '1, '1));
    send_word(make_word(MODE_MAP, page_addr(2), '0, 13'd3));
    send_word(make_word(MODE_XLAT, '1, '0, '0));
    send_word(make_word(MODE_UNMAP, '0, '1, 13'd8));
    send_word(make_word(MODE_UNMAP, page_addr(9), '0, 13'd0));
    send_word(make_word(MODE_MAP, '0, 48'h1234_5678_9000, CNT_W'(TABLE_ENTRIES)));
    send_word(make_word(MODE_XLAT, page_addr(TABLE_ENTRIES - 1) | 48'hABC, '0, '0));
    send_word(make_word(MODE_MAP, page_addr(100), 48'h1000, 13'd1));
    send_word(make_word(MODE_UNMAP, '0, '0, CNT_W'(TABLE_ENTRIES)));
    send_word(make_word(MODE_UNMAP, page_addr(TABLE_ENTRIES - 1), '0, 13'd1));
    send_word(make_word(MODE_UNMAP, top_pa, '0, 13'd1));
    drain_responses();
  endtask

  task automatic test_random_sequences(int unsigned n_items);
    int unsigned roll;
    int unsigned pg;
    logic [ADDR_W-1:0] ioa;
    logic [ADDR_W-1:0] pa;
    for (int unsigned k = 0; k < n_items; k++) begin
      roll = $urandom_range(0, 99);
      pa   = rand48() & ~48'(2 ** PAGE_BITS - 1);
      if (roll < 40) begin
        pg  = $urandom_range(0, TABLE_ENTRIES - 1);
        ioa = page_addr(pg);
        if ($urandom_range(0, 19) == 0) ioa |= $urandom_range(1, 2 ** PAGE_BITS - 1);
        if ($urandom_range(0, 19) == 0) pa |= $urandom_range(1, 2 ** PAGE_BITS - 1);
        map_starts.push_back(pg);
        if (map_starts.size() > 64) void'(map_starts.pop_front());
        send_word(make_word(MODE_MAP, ioa, pa, pick_count()));
      end else if (roll < 65) begin
        pg = (map_starts.size() != 0 && $urandom_range(0, 9) < 7)
             ? map_starts[$urandom_range(0, map_starts.size() - 1)]
             : $urandom_range(0, TABLE_ENTRIES - 1);
        send_word(make_word(MODE_UNMAP, page_addr(pg), rand48(), pick_count()));
      end else if (roll < 95) begin
        pg = (map_starts.size() != 0 && $urandom_range(0, 9) < 7)
             ? map_starts[$urandom_range(0, map_starts.size() - 1)] + $urandom_range(0, 3)
             : $urandom_range(0, TABLE_ENTRIES + 15);
        ioa = page_addr(pg) | $urandom_range(0, 2 ** PAGE_BITS - 1);
        send_word(make_word(MODE_XLAT, ioa, rand48(), CNT_W'($urandom())));
      end else begin
        send_word(make_word(MODE_NOP, rand48(), rand48(), CNT_W'($urandom())));
      end
      if (k % 150 == 149) drain_responses();
    end
    drain_responses();
  endtask

  task automatic test_random_noise(int unsigned n_items);
    for (int unsigned k = 0; k < n_items; k++)
      send_word(make_word(mode_e'($urandom_range(0, 3)), rand48(), rand48(),
                          CNT_W'($urandom())));
    drain_responses();
  endtask

  task automatic test_back_to_back_xlat(int unsigned n_items);
    logic [ADDR_W-1:0] ioa;
    tx_steady = 1'b1;
    rx_steady = 1'b1;
    for (int unsigned k = 0; k < 8; k++)
      send_word(make_word(MODE_MAP, page_addr(k * 16), rand48() & ~48'hFFF, 13'd8));
    for (int unsigned k = 0; k < n_items; k++) begin
      ioa = page_addr($urandom_range(0, 127)) | $urandom_range(0, 2 ** PAGE_BITS - 1);
      send_word(make_word(MODE_XLAT, ioa, '0, '0));
    end
    drain_responses();
    tx_steady = 1'b0;
    rx_steady = 1'b0;
  endtask

  initial begin
    rst_ni      = 1'b0;
    push        = 1'b0;
    pop         = 1'b0;
    in_word_i   = '0;
    err_count   = 0;
    idle_cycles = 0;
    rx_stall    = 0;
    tx_steady   = 1'b0;
    rx_steady   = 1'b0;
    for (int unsigned i = 0; i < TABLE_ENTRIES; i++) begin
      pte_valid[i] = 1'b0;
      pte_ppn[i]   = '0;
    end
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_random_sequences(600);
    test_random_noise(150);
    test_back_to_back_xlat(120);

    repeat (20) @(posedge clk_i);
    if (expected_rsp_q.size() != 0)
      flag_mismatch("words never returned", expected_rsp_q.size(), '0);
    if (err_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

/* sim.f */
src/iopt_pkg.sv
src/iopt_fifo.sv
src/iopt_front.sv
src/iopt_back.sv
src/io_page_translation_table_core.sv
bench/io_page_translation_table_core_tb.sv
